[rtl/byte_ring_fifo_core_assert.svh]
// assertion helpers shared by the ring fifo modules
`ifndef BYTE_RING_FIFO_CORE_ASSERT_SVH
`define BYTE_RING_FIFO_CORE_ASSERT_SVH

// condition must hold on every clock outside reset
`define BRF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in this cycle
`define BRF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/brf_pkg.sv]
package brf_pkg;

    localparam int MAX_DEPTH_LOG2_DEF = 8;
    localparam int MAX_XFER_DEF       = 63;
    localparam int CMDQ_DEPTH_DEF     = 4;
    localparam int CNT_W              = 6;
    localparam int BYTE_W             = 8;
    localparam int LVL_W              = 8;
    localparam int CFG_W              = 4;
    localparam int REQ_W              = 3;
    localparam int PTR_W_MAX          = 16;
    localparam int IN_TDATA_W         = 16;
    localparam int OUT_TDATA_W        = 32;
    localparam int SIZE_LOG2_RESET    = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE_START   = 3'd0,
        REQ_WRITE_DATA    = 3'd1,
        REQ_READ          = 3'd2,
        REQ_PEEK          = 3'd3,
        REQ_ADVANCE_READ  = 3'd4,
        REQ_ADVANCE_WRITE = 3'd5,
        REQ_CLEAR         = 3'd6,
        REQ_QUERY         = 3'd7
    } t_req;

    // one queued job for the back end: a single status result or a read run
    typedef struct packed {
        logic             is_read;
        logic [CNT_W-1:0] granted;
        logic [LVL_W-1:0] fill;
        logic [LVL_W-1:0] free;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]  granted;
        logic [BYTE_W-1:0] read_byte;
        logic              last;
        logic [LVL_W-1:0]  fill;
        logic [LVL_W-1:0]  free;
    } t_res;

    function automatic logic [LVL_W-1:0] sat8(input logic [PTR_W_MAX-1:0] v);
        logic [LVL_W-1:0] r;
        r = (v > PTR_W_MAX'(255)) ? {LVL_W{1'b1}} : v[LVL_W-1:0];
        return r;
    endfunction

endpackage

[rtl/brf_ram.sv]
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/brf_cmdq.sv]
module brf_cmdq #(
    parameter int WIDTH = 32,
    parameter int DEPTH = brf_pkg::CMDQ_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/brf_front.sv]
module brf_front #(
    parameter int MAX_DEPTH_LOG2 = brf_pkg::MAX_DEPTH_LOG2_DEF,
    parameter int MAX_XFER       = brf_pkg::MAX_XFER_DEF,
    parameter int CMDQ_DEPTH     = brf_pkg::CMDQ_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [brf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  logic [brf_pkg::REQ_W-1:0]      i_req_type,
    input  logic [brf_pkg::CNT_W-1:0]      i_count,
    input  logic                           i_allow_partial,
    input  logic [brf_pkg::BYTE_W-1:0]     i_data_byte,
    output logic                           o_cmd_push,
    output brf_pkg::t_cmd                  o_cmd,
    output logic [MAX_DEPTH_LOG2-1:0]      o_cmd_addr,
    input  logic                           i_cmd_full,
    input  logic                           i_rd_done,
    output logic [MAX_DEPTH_LOG2-1:0]      o_mask,
    output logic                           o_ram_we,
    output logic [MAX_DEPTH_LOG2-1:0]      o_ram_waddr,
    output logic [brf_pkg::BYTE_W-1:0]     o_ram_wdata
);

    `include "byte_ring_fifo_core_assert.svh"

    localparam int PW = MAX_DEPTH_LOG2;
    localparam int SW = $clog2(MAX_DEPTH_LOG2 + 1);
    localparam int NW = brf_pkg::CNT_W;
    localparam int GW = (PW > NW) ? PW : NW;
    localparam int OW = $clog2(CMDQ_DEPTH + 2);
    localparam int SIZE_RST_I = (brf_pkg::SIZE_LOG2_RESET > MAX_DEPTH_LOG2) ?
                                MAX_DEPTH_LOG2 : brf_pkg::SIZE_LOG2_RESET;
    localparam logic [SW-1:0] SIZE_RST  = SW'(SIZE_RST_I);
    localparam logic [4:0]    SIZE_MAX  = 5'(MAX_DEPTH_LOG2);
    localparam logic [NW-1:0] XFER_CAP  = NW'(MAX_XFER);
    localparam logic [OW-1:0] RD_MAX    = OW'(CMDQ_DEPTH + 1);

    logic [SW-1:0] r_size;
    logic [PW-1:0] r_rp, r_wp, n_rp, n_wp;
    logic [NW-1:0] r_wleft, r_woff, n_wleft, n_woff;
    logic [OW-1:0] r_rd_out;

    brf_pkg::t_req req;
    logic [PW-1:0] mask, fill, free, lvl_fill, lvl_free;
    logic [NW-1:0] cnt, grant;
    logic [GW-1:0] cnt_g, avail_g;
    logic          refuse, is_wdata, accept, push, push_read;
    logic [4:0]    cfg_v, cfg_sel;

    assign req      = brf_pkg::t_req'(i_req_type);
    assign mask     = ~({PW{1'b1}} << r_size);
    assign fill     = (r_wp - r_rp) & mask;
    assign free     = mask - fill;
    assign cnt      = (i_count > XFER_CAP) ? XFER_CAP : i_count;
    assign cnt_g    = GW'(cnt);
    assign avail_g  = (req == brf_pkg::REQ_WRITE_START) ? GW'(free) : GW'(fill);
    assign refuse   = (cnt == '0) || (avail_g == '0) || ((avail_g < cnt_g) && !i_allow_partial);
    assign grant    = refuse ? '0 : ((avail_g < cnt_g) ? avail_g[NW-1:0] : cnt);
    assign is_wdata = (req == brf_pkg::REQ_WRITE_DATA);

    // writes wait while a read run may still fetch from the ring
    assign o_req_ready = !i_cmd_full && !(is_wdata && (r_rd_out != '0));
    assign accept      = i_req_valid && o_req_ready;

    always_comb begin
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_wleft   = r_wleft;
        n_woff    = r_woff;
        push      = 1'b1;
        push_read = 1'b0;
        o_cmd.is_read = 1'b0;
        o_cmd.granted = '0;
        o_ram_we      = 1'b0;
        o_ram_waddr   = (r_wp + PW'(r_woff)) & mask;
        unique case (req)
            brf_pkg::REQ_WRITE_START: begin
                o_cmd.granted = grant;
                n_wleft       = grant;
                n_woff        = '0;
            end
            brf_pkg::REQ_WRITE_DATA: begin
                push = 1'b0;
                if (r_wleft != '0) begin
                    o_ram_we = accept;
                    if (r_wleft == NW'(1)) begin
                        // final byte of the grant commits the write pointer
                        push          = 1'b1;
                        o_cmd.granted = r_woff + NW'(1);
                        n_wp          = (r_wp + PW'(r_woff + NW'(1))) & mask;
                        n_wleft       = '0;
                        n_woff        = '0;
                    end else begin
                        n_wleft = r_wleft - NW'(1);
                        n_woff  = r_woff + NW'(1);
                    end
                end
            end
            brf_pkg::REQ_READ, brf_pkg::REQ_PEEK: begin
                o_cmd.is_read = !refuse;
                o_cmd.granted = grant;
                push_read     = !refuse;
                if (req == brf_pkg::REQ_READ) begin
                    n_rp = (r_rp + PW'(grant)) & mask;
                end
            end
            brf_pkg::REQ_ADVANCE_READ: begin
                o_cmd.granted = cnt;
                n_rp          = (r_rp + PW'(cnt)) & mask;
            end
            brf_pkg::REQ_ADVANCE_WRITE: begin
                o_cmd.granted = cnt;
                n_wp          = (r_wp + PW'(cnt)) & mask;
            end
            brf_pkg::REQ_CLEAR: begin
                n_rp    = '0;
                n_wp    = '0;
                n_wleft = '0;
                n_woff  = '0;
            end
            brf_pkg::REQ_QUERY: begin
                push = 1'b1;
            end
            default: begin
                push = 1'b1;
            end
        endcase
        lvl_fill   = (n_wp - n_rp) & mask;
        lvl_free   = mask - lvl_fill;
        o_cmd.fill = brf_pkg::sat8(brf_pkg::PTR_W_MAX'(lvl_fill));
        o_cmd.free = brf_pkg::sat8(brf_pkg::PTR_W_MAX'(lvl_free));
    end

    assign o_cmd_addr  = r_rp;
    assign o_cmd_push  = accept && push;
    assign o_mask      = mask;
    assign o_ram_wdata = i_data_byte;

    assign cfg_v   = {1'b0, i_cfg_data};
    assign cfg_sel = (cfg_v == '0) ? 5'd1 : ((cfg_v > SIZE_MAX) ? SIZE_MAX : cfg_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= SIZE_RST;
            r_rp     <= '0;
            r_wp     <= '0;
            r_wleft  <= '0;
            r_woff   <= '0;
            r_rd_out <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_size  <= cfg_sel[SW-1:0];
                r_rp    <= '0;
                r_wp    <= '0;
                r_wleft <= '0;
                r_woff  <= '0;
            end else if (accept) begin
                r_rp    <= n_rp;
                r_wp    <= n_wp;
                r_wleft <= n_wleft;
                r_woff  <= n_woff;
            end
            case ({accept && push_read, i_rd_done})
                2'b10:   r_rd_out <= r_rd_out + OW'(1);
                2'b01:   r_rd_out <= r_rd_out - OW'(1);
                default: r_rd_out <= r_rd_out;
            endcase
        end
    end

    `BRF_ASSERT_IMPL(a_wdata_no_read, accept && is_wdata, r_rd_out == '0, "write during read run")
    `BRF_ASSERT_IMPL(a_woff_idle, r_wleft == '0, r_woff == '0, "offset left without pending write")
    `BRF_ASSERT_ALWAYS(a_rd_out_bound, r_rd_out <= RD_MAX, "read run count overflow")

endmodule

[rtl/brf_back.sv]
module brf_back #(
    parameter int MAX_DEPTH_LOG2 = brf_pkg::MAX_DEPTH_LOG2_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_empty,
    input  brf_pkg::t_cmd                  i_cmd,
    input  logic [MAX_DEPTH_LOG2-1:0]      i_cmd_addr,
    output logic                           o_cmd_pop,
    input  logic [MAX_DEPTH_LOG2-1:0]      i_mask,
    output logic                           o_ram_re,
    output logic [MAX_DEPTH_LOG2-1:0]      o_ram_raddr,
    input  logic [brf_pkg::BYTE_W-1:0]     i_ram_rdata,
    output logic                           o_rd_done,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output brf_pkg::t_res                  o_res
);

    `include "byte_ring_fifo_core_assert.svh"

    localparam int PW = MAX_DEPTH_LOG2;
    localparam int NW = brf_pkg::CNT_W;

    typedef struct packed {
        brf_pkg::t_cmd cmd;
        logic          last;
    } t_s1;

    logic          r_busy;
    brf_pkg::t_cmd r_cmd;
    logic [PW-1:0] r_addr;
    logic [NW-1:0] r_left;
    logic          r_s1_valid;
    t_s1           r_s1;
    brf_pkg::t_res r_ob [2];
    logic          r_ohead;
    logic [1:0]    r_ocnt;

    logic          pop_out, credit, start, cont, issue, last;
    brf_pkg::t_res ob_in;

    assign pop_out = o_res_valid && i_res_ready;
    // an issued entry passes through the r_s1 stage before it lands in the output buffer
    assign credit  = ({1'b0, r_ocnt} + {2'b0, r_s1_valid}) < (3'd2 + {2'b0, pop_out});
    assign start   = !r_busy && !i_cmd_empty && credit;
    assign cont    = r_busy && credit;
    assign issue   = start || cont;
    assign last    = r_busy ? (r_left == NW'(1)) : (!i_cmd.is_read || (i_cmd.granted == NW'(1)));

    assign o_cmd_pop   = start;
    assign o_ram_re    = cont || (start && i_cmd.is_read);
    assign o_ram_raddr = r_busy ? r_addr : i_cmd_addr;
    assign o_rd_done   = (start && i_cmd.is_read && (i_cmd.granted == NW'(1)))
                       || (cont && (r_left == NW'(1)));

    assign ob_in.granted   = r_s1.cmd.granted;
    assign ob_in.read_byte = r_s1.cmd.is_read ? i_ram_rdata : '0;
    assign ob_in.last      = r_s1.last;
    assign ob_in.fill      = r_s1.cmd.fill;
    assign ob_in.free      = r_s1.cmd.free;

    assign o_res_valid = (r_ocnt != 2'd0);
    assign o_res       = r_ob[r_ohead];

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1.cmd  <= r_busy ? r_cmd : i_cmd;
            r_s1.last <= last;
        end
        if (start) begin
            r_cmd  <= i_cmd;
            r_addr <= (i_cmd_addr + PW'(1)) & i_mask;
            r_left <= i_cmd.granted - NW'(1);
        end else if (cont) begin
            r_addr <= (r_addr + PW'(1)) & i_mask;
            r_left <= r_left - NW'(1);
        end
        if (r_s1_valid) begin
            r_ob[r_ohead ^ r_ocnt[0]] <= ob_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_ohead    <= 1'b0;
            r_ocnt     <= 2'd0;
        end else begin
            r_s1_valid <= issue;
            if (start) begin
                r_busy <= i_cmd.is_read && (i_cmd.granted != NW'(1));
            end else if (cont && (r_left == NW'(1))) begin
                r_busy <= 1'b0;
            end
            if (pop_out) begin
                r_ohead <= ~r_ohead;
            end
            case ({r_s1_valid, pop_out})
                2'b10:   r_ocnt <= r_ocnt + 2'd1;
                2'b01:   r_ocnt <= r_ocnt - 2'd1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    `BRF_ASSERT_ALWAYS(a_ob_room, ({1'b0, r_ocnt} + {2'b0, r_s1_valid}) <= 3'd2, "output overrun")
    `BRF_ASSERT_IMPL(a_busy_left, r_busy, r_left != '0, "read run with no bytes left")
    `BRF_ASSERT_NEXT(a_done_idle, o_rd_done, !r_busy, "read run still busy after done")

endmodule

[rtl/byte_ring_fifo_core.sv]
// Byte FIFO in a ring of 2^size_log2 slots, one slot always kept empty. Each request on the
// slave stream is taken by the front end, which updates the pointers and queues the job; the
// back end turns it into results on the master stream. A granted read or peek streams its
// bytes at one byte per cycle unless the output stalls, from the ring memory (one registered
// read port), the final one marked with tlast; write_data gives a result only on the last
// byte of its grant, every other request one result. write_data transfers are taken one per
// cycle, except that they wait while the job queue is full or a read or peek run is queued or
// streaming. Results pass the job queue, r_s1 stage and output buffer. Ring needs no clearing
// after reset; writing size_log2 (only while idle) empties the ring and drops a pending write.
module byte_ring_fifo_core #(
    parameter int MAX_DEPTH_LOG2 = brf_pkg::MAX_DEPTH_LOG2_DEF,
    parameter int MAX_XFER       = brf_pkg::MAX_XFER_DEF,
    parameter int CMDQ_DEPTH     = brf_pkg::CMDQ_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [brf_pkg::CFG_W-1:0]          i_cfg_data,      // size_log2
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // count[5:0], allow_partial[6], data_byte[14:7], zero pad[15]
    input  logic [brf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic [brf_pkg::REQ_W-1:0]          i_s_axis_tuser,  // req_type
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // granted[5:0], read_byte[13:6], bytes_to_read[21:14], bytes_to_write[29:22], pad[31:30]
    output logic [brf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tlast
);

    localparam int PW   = MAX_DEPTH_LOG2;
    localparam int QW   = $bits(brf_pkg::t_cmd) + PW;
    localparam int RESW = $bits(brf_pkg::t_res) - 1;

    logic                        cmd_push, cmd_full, cmd_pop, cmd_empty, rd_done;
    brf_pkg::t_cmd               cmd_in, cmd_out;
    logic [PW-1:0]               cmd_addr_in, cmd_addr_out, mask;
    logic [QW-1:0]               q_out;
    logic                        ram_we, ram_re;
    logic [PW-1:0]               ram_waddr, ram_raddr;
    logic [brf_pkg::BYTE_W-1:0]  ram_wdata, ram_rdata;
    brf_pkg::t_res               res;

    assign o_cfg_ready = 1'b1;

    brf_front #(
        .MAX_DEPTH_LOG2 (MAX_DEPTH_LOG2),
        .MAX_XFER       (MAX_XFER),
        .CMDQ_DEPTH     (CMDQ_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_req_valid     (i_s_axis_tvalid),
        .o_req_ready     (o_s_axis_tready),
        .i_req_type      (i_s_axis_tuser),
        .i_count         (i_s_axis_tdata[5:0]),
        .i_allow_partial (i_s_axis_tdata[6]),
        .i_data_byte     (i_s_axis_tdata[14:7]),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd_in),
        .o_cmd_addr      (cmd_addr_in),
        .i_cmd_full      (cmd_full),
        .i_rd_done       (rd_done),
        .o_mask          (mask),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata)
    );

    brf_cmdq #(
        .WIDTH (QW),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  ({cmd_in, cmd_addr_in}),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (q_out)
    );

    assign cmd_out      = brf_pkg::t_cmd'(q_out[QW-1:PW]);
    assign cmd_addr_out = q_out[PW-1:0];

    brf_ram #(
        .WIDTH (brf_pkg::BYTE_W),
        .DEPTH (2 ** MAX_DEPTH_LOG2)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    brf_back #(
        .MAX_DEPTH_LOG2 (MAX_DEPTH_LOG2)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .i_cmd_addr  (cmd_addr_out),
        .o_cmd_pop   (cmd_pop),
        .i_mask      (mask),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_rd_done   (rd_done),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = brf_pkg::OUT_TDATA_W'({res.free, res.fill, res.read_byte,
                                                   res.granted});
    assign o_m_axis_tlast = res.last;

    // fields without last must fit within tdata
    localparam int USED_W = RESW;
    if (USED_W > brf_pkg::OUT_TDATA_W) begin : g_bad_width
        brf_pkg::t_res width_check_fail;
        assign width_check_fail = res;
    end

endmodule
